@@ hw/rtl/psp_pkg.sv @@
package psp_pkg;

  localparam logic [1:0] CMD_ROUTE    = 2'd0;
  localparam logic [1:0] CMD_ADD_DEF  = 2'd1;
  localparam logic [1:0] CMD_ADD_DEST = 2'd2;

  localparam logic [1:0] OP_ROUTE    = 2'd0;
  localparam logic [1:0] OP_ADD_DEF  = 2'd1;
  localparam logic [1:0] OP_ADD_DEST = 2'd2;
  localparam logic [1:0] OP_REJECT   = 2'd3;

  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_NO_ROUTE       = 3'd1;
  localparam logic [2:0] ST_NO_PATHS       = 3'd2;
  localparam logic [2:0] ST_WEIGHT_REFUSED = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL     = 3'd4;

  localparam logic [15:0] LFSR_SEED = 16'd44257;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  rej_status;
    logic [31:0] key;
    logic [31:0] dest_addr;
    logic [6:0]  weight;
    logic [31:0] path_id;
  } fq_t;

endpackage

@@ hw/rtl/per_flow_round_robin_path_sprayer.sv @@
// channel  | handshake            | payload
// in       | in_valid / in_ready  | command, flow_id, flow_tag_present, dest_addr, weight, path_id
// out      | out_valid / out_ready| status, assigned_path
// cfg      | cfg_wr_en            | cfg_wr_data (mode)
//
// a route scans up to D override keys and then up to F flow keys, one a cycle from their
// memories, then waits on the bit-serial remainder unit
// a default add appends weight entries; a destination add scans the D override keys and appends
// weight entries, first copying the default list into a new override list for a new destination
// a two-word queue decouples input from the engine; a result register holds the output word
// synchronous active-low reset; tables are filled in order, no clearing pass
module per_flow_round_robin_path_sprayer #(
  parameter int PATH_SLOTS  = 64,
  parameter int DEST_TABLES = 16,
  parameter int FLOW_SLOTS  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_flow_id,
  input  logic        in_flow_tag_present,
  input  logic [31:0] in_dest_addr,
  input  logic [6:0]  in_weight,
  input  logic [31:0] in_path_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_assigned_path
);

  logic         mode_r, mode_nxt;
  logic         q_valid, q_pop;
  psp_pkg::fq_t q_word;

  assign mode_nxt = cfg_wr_en ? cfg_wr_data : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  psp_front u_front (
    .clk(clk), .rst_n(rst_n), .mode(mode_r),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_flow_id(in_flow_id), .in_flow_tag_present(in_flow_tag_present),
    .in_dest_addr(in_dest_addr), .in_weight(in_weight), .in_path_id(in_path_id),
    .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop)
  );

  psp_back #(
    .PATH_SLOTS(PATH_SLOTS), .DEST_TABLES(DEST_TABLES), .FLOW_SLOTS(FLOW_SLOTS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_assigned_path(out_assigned_path)
  );

  a_pop_valid : assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_path_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != psp_pkg::ST_OK |-> out_assigned_path == 32'd0)
    else $error("path on failed word");

  a_status_rng : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= psp_pkg::ST_TABLE_FULL)
    else $error("bad status code");

  a_reset_idle : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word after reset");

endmodule

@@ hw/rtl/psp_ram.sv @@
module psp_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                     wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                     rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/psp_front.sv @@
module psp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mode,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_command,
  input  logic [31:0]         in_flow_id,
  input  logic                in_flow_tag_present,
  input  logic [31:0]         in_dest_addr,
  input  logic [6:0]          in_weight,
  input  logic [31:0]         in_path_id,
  output logic                q_valid,
  output psp_pkg::fq_t        q_word,
  input  logic                q_pop
);

  psp_pkg::fq_t cls;
  psp_pkg::fq_t ent_r [2];
  logic         wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         push;

  // classify the incoming word
  always_comb begin
    cls.op         = psp_pkg::OP_REJECT;
    cls.rej_status = psp_pkg::ST_NO_ROUTE;
    cls.key        = mode ? in_flow_id : in_dest_addr;
    cls.dest_addr  = in_dest_addr;
    cls.weight     = in_weight;
    cls.path_id    = in_path_id;
    case (in_command)
      psp_pkg::CMD_ROUTE: begin
        if (!(mode && !in_flow_tag_present)) begin
          cls.op = psp_pkg::OP_ROUTE;
        end
      end
      psp_pkg::CMD_ADD_DEF: begin
        if (in_weight != 7'd1 && !mode) begin
          cls.rej_status = psp_pkg::ST_WEIGHT_REFUSED;
        end else begin
          cls.op = psp_pkg::OP_ADD_DEF;
        end
      end
      psp_pkg::CMD_ADD_DEST: begin
        cls.op = psp_pkg::OP_ADD_DEST;
      end
      default: begin
        cls.op = psp_pkg::OP_REJECT;
      end
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cls;
    end
  end

endmodule

@@ hw/rtl/psp_mod.sv @@
module psp_mod #(
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [15:0]   dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] result
);

  logic [VW-1:0] rem_r, rem_nxt;
  logic [15:0]   sh_r, sh_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   trial;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    trial    = {rem_r, sh_r[15]};
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      sh_nxt   = dividend;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = VW'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[VW-1:0];
      end
      sh_nxt  = {sh_r[14:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done   = done_r;
  assign result = rem_r;

endmodule

@@ hw/rtl/psp_back.sv @@
module psp_back #(
  parameter int PATH_SLOTS  = 64,
  parameter int DEST_TABLES = 16,
  parameter int FLOW_SLOTS  = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  psp_pkg::fq_t q_word,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   out_status,
  output logic [31:0]  out_assigned_path
);

  localparam int CW   = $clog2(PATH_SLOTS + 1);
  localparam int PW   = $clog2(PATH_SLOTS);
  localparam int TW   = DEST_TABLES > 1 ? $clog2(DEST_TABLES) : 1;
  localparam int DD   = DEST_TABLES * PATH_SLOTS;
  localparam int DPW  = $clog2(DD);
  localparam int FW   = $clog2(FLOW_SLOTS);
  localparam int DUW  = $clog2(DEST_TABLES + 1);
  localparam int FUW  = $clog2(FLOW_SLOTS + 1);
  localparam int SW0  = DUW > FUW ? DUW : FUW;
  localparam int SCW  = SW0 > CW ? SW0 : CW;
  localparam int SUMW = (CW > 7 ? CW : 7) + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DSRCH = 4'd1;
  localparam logic [3:0] S_COPY  = 4'd2;
  localparam logic [3:0] S_APP   = 4'd3;
  localparam logic [3:0] S_FSRCH = 4'd4;
  localparam logic [3:0] S_MODGO = 4'd5;
  localparam logic [3:0] S_MODW  = 4'd6;
  localparam logic [3:0] S_PREAD = 4'd7;
  localparam logic [3:0] S_PDATA = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]     st_r, st_nxt;
  psp_pkg::fq_t   w_r, w_nxt;
  logic [SCW-1:0] scan_r, scan_nxt, scan_m1;
  logic           cmpv_r, cmpv_nxt;
  logic           dst_r, dst_nxt;
  logic [TW-1:0]  t_r, t_nxt;
  logic [DPW-1:0] base_r, base_nxt;
  logic [CW-1:0]  len_r, len_nxt;
  logic [FW-1:0]  f_r, f_nxt;
  logic [15:0]    div_r, div_nxt;
  logic [PW-1:0]  idx_r, idx_nxt;
  logic [DPW-1:0] wptr_r, wptr_nxt;
  logic [6:0]     rem_r, rem_nxt;
  logic [15:0]    lfsr_r, lfsr_nxt;
  logic [DUW-1:0] dused_r, dused_nxt;
  logic [FUW-1:0] fused_r, fused_nxt;
  logic [CW-1:0]  dcnt_r, dcnt_nxt;
  logic [2:0]     status_r, status_nxt;
  logic [31:0]    path_r, path_nxt;
  logic           ov_r, ov_nxt;
  logic [2:0]     os_r, os_nxt;
  logic [31:0]    op_r, op_nxt;

  logic           def_we;
  logic [PW-1:0]  def_wa, def_ra;
  logic [31:0]    def_rd;
  logic           dp_we;
  logic [DPW-1:0] dp_wa, dp_ra;
  logic [31:0]    dp_wd, dp_rd;
  logic           dk_we;
  logic [31:0]    dk_rd;
  logic           dc_we;
  logic [CW-1:0]  dc_wd, dc_rd;
  logic           fk_we;
  logic [31:0]    fk_rd;
  logic           fn_we;
  logic [PW-1:0]  fn_wd, fn_rd;
  logic           mod_start, mod_done;
  logic [CW-1:0]  mod_res;
  logic [SUMW-1:0] def_sum, dc_sum;
  logic [PW:0]    idx_inc;

  assign scan_m1 = scan_r - SCW'(1);
  assign def_sum = SUMW'(dcnt_r) + SUMW'(w_r.weight);
  assign dc_sum  = SUMW'(dc_rd) + SUMW'(w_r.weight);
  assign idx_inc = {1'b0, idx_r} + (PW+1)'(1);

  always_comb begin
    st_nxt     = st_r;
    w_nxt      = w_r;
    scan_nxt   = scan_r;
    cmpv_nxt   = cmpv_r;
    dst_nxt    = dst_r;
    t_nxt      = t_r;
    base_nxt   = base_r;
    len_nxt    = len_r;
    f_nxt      = f_r;
    div_nxt    = div_r;
    idx_nxt    = idx_r;
    wptr_nxt   = wptr_r;
    rem_nxt    = rem_r;
    lfsr_nxt   = lfsr_r;
    dused_nxt  = dused_r;
    fused_nxt  = fused_r;
    dcnt_nxt   = dcnt_r;
    status_nxt = status_r;
    path_nxt   = path_r;
    ov_nxt     = ov_r;
    os_nxt     = os_r;
    op_nxt     = op_r;
    q_pop      = 1'b0;
    def_we     = 1'b0;
    def_wa     = wptr_r[PW-1:0];
    def_ra     = (st_r == S_COPY) ? scan_r[PW-1:0] : idx_r;
    dp_we      = 1'b0;
    dp_wa      = wptr_r;
    dp_wd      = w_r.path_id;
    dp_ra      = base_r + DPW'(idx_r);
    dk_we      = 1'b0;
    dc_we      = 1'b0;
    dc_wd      = dcnt_r;
    fk_we      = 1'b0;
    fn_we      = 1'b0;
    fn_wd      = (idx_inc == (PW+1)'(len_r)) ? '0 : idx_inc[PW-1:0];
    mod_start  = 1'b0;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          w_nxt    = q_word;
          scan_nxt = '0;
          cmpv_nxt = 1'b0;
          case (q_word.op)
            psp_pkg::OP_ROUTE, psp_pkg::OP_ADD_DEST: begin
              st_nxt = S_DSRCH;
            end
            psp_pkg::OP_ADD_DEF: begin
              if ((SUMW'(dcnt_r) + SUMW'(q_word.weight)) > SUMW'(PATH_SLOTS)) begin
                status_nxt = psp_pkg::ST_TABLE_FULL;
                st_nxt     = S_DONE;
              end else begin
                dst_nxt  = 1'b0;
                wptr_nxt = DPW'(dcnt_r);
                rem_nxt  = q_word.weight;
                dcnt_nxt = CW'(SUMW'(dcnt_r) + SUMW'(q_word.weight));
                st_nxt   = S_APP;
              end
            end
            default: begin
              status_nxt = q_word.rej_status;
              st_nxt     = S_DONE;
            end
          endcase
        end
      end

      S_DSRCH: begin
        if ((cmpv_r && dk_rd == w_r.dest_addr) || scan_r == SCW'(dused_r)) begin
          if (cmpv_r && dk_rd == w_r.dest_addr) begin
            t_nxt    = scan_m1[TW-1:0];
            base_nxt = DPW'(scan_m1[TW-1:0]) * DPW'(PATH_SLOTS);
            if (w_r.op == psp_pkg::OP_ROUTE) begin
              dst_nxt = 1'b1;
              len_nxt = dc_rd;
            end else if (dc_sum > SUMW'(PATH_SLOTS)) begin
              status_nxt = psp_pkg::ST_TABLE_FULL;
              st_nxt     = S_DONE;
            end else begin
              dst_nxt  = 1'b1;
              dc_we    = 1'b1;
              dc_wd    = CW'(dc_sum);
              wptr_nxt = DPW'(scan_m1[TW-1:0]) * DPW'(PATH_SLOTS) + DPW'(dc_rd);
              rem_nxt  = w_r.weight;
              st_nxt   = S_APP;
            end
          end else if (w_r.op == psp_pkg::OP_ROUTE) begin
            dst_nxt = 1'b0;
            len_nxt = dcnt_r;
          end else if (dused_r == DUW'(DEST_TABLES) || def_sum > SUMW'(PATH_SLOTS)) begin
            status_nxt = psp_pkg::ST_TABLE_FULL;
            st_nxt     = S_DONE;
          end else begin
            t_nxt     = dused_r[TW-1:0];
            base_nxt  = DPW'(dused_r[TW-1:0]) * DPW'(PATH_SLOTS);
            dk_we     = 1'b1;
            dc_we     = 1'b1;
            dc_wd     = CW'(def_sum);
            dused_nxt = dused_r + DUW'(1);
            dst_nxt   = 1'b1;
            scan_nxt  = '0;
            cmpv_nxt  = 1'b0;
            st_nxt    = S_COPY;
          end
          if (w_r.op == psp_pkg::OP_ROUTE) begin
            scan_nxt = '0;
            cmpv_nxt = 1'b0;
            if ((cmpv_r && dk_rd == w_r.dest_addr) ? (dc_rd == '0) : (dcnt_r == '0)) begin
              status_nxt = psp_pkg::ST_NO_PATHS;
              st_nxt     = S_DONE;
            end else begin
              st_nxt = S_FSRCH;
            end
          end
        end else begin
          scan_nxt = scan_r + SCW'(1);
          cmpv_nxt = 1'b1;
        end
      end

      S_COPY: begin
        // default list into the new override list, one entry a cycle
        if (cmpv_r) begin
          dp_we = 1'b1;
          dp_wa = base_r + DPW'(scan_m1);
          dp_wd = def_rd;
        end
        if (scan_r == SCW'(dcnt_r)) begin
          wptr_nxt = base_r + DPW'(dcnt_r);
          rem_nxt  = w_r.weight;
          st_nxt   = S_APP;
        end else begin
          scan_nxt = scan_r + SCW'(1);
          cmpv_nxt = 1'b1;
        end
      end

      S_APP: begin
        if (rem_r == 7'd0) begin
          status_nxt = psp_pkg::ST_OK;
          st_nxt     = S_DONE;
        end else begin
          def_we   = !dst_r;
          dp_we    = dst_r;
          wptr_nxt = wptr_r + DPW'(1);
          rem_nxt  = rem_r - 7'd1;
        end
      end

      S_FSRCH: begin
        if (cmpv_r && fk_rd == w_r.key) begin
          f_nxt   = scan_m1[FW-1:0];
          div_nxt = 16'(fn_rd);
          st_nxt  = S_MODGO;
        end else if (scan_r == SCW'(fused_r)) begin
          if (fused_r == FUW'(FLOW_SLOTS)) begin
            status_nxt = psp_pkg::ST_TABLE_FULL;
            st_nxt     = S_DONE;
          end else begin
            f_nxt     = fused_r[FW-1:0];
            fk_we     = 1'b1;
            fused_nxt = fused_r + FUW'(1);
            div_nxt   = lfsr_r;
            lfsr_nxt  = (lfsr_r >> 1) ^ (lfsr_r[0] ? psp_pkg::LFSR_TAPS : 16'd0);
            st_nxt    = S_MODGO;
          end
        end else begin
          scan_nxt = scan_r + SCW'(1);
          cmpv_nxt = 1'b1;
        end
      end

      S_MODGO: begin
        mod_start = 1'b1;
        st_nxt    = S_MODW;
      end

      S_MODW: begin
        if (mod_done) begin
          idx_nxt = mod_res[PW-1:0];
          st_nxt  = S_PREAD;
        end
      end

      S_PREAD: begin
        st_nxt = S_PDATA;
      end

      S_PDATA: begin
        fn_we      = 1'b1;
        path_nxt   = dst_r ? dp_rd : def_rd;
        status_nxt = psp_pkg::ST_OK;
        st_nxt     = S_DONE;
      end

      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          os_nxt = status_r;
          op_nxt = (status_r == psp_pkg::ST_OK && w_r.op == psp_pkg::OP_ROUTE) ? path_r : '0;
          st_nxt = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      cmpv_r  <= 1'b0;
      lfsr_r  <= psp_pkg::LFSR_SEED;
      dused_r <= '0;
      fused_r <= '0;
      dcnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cmpv_r  <= cmpv_nxt;
      lfsr_r  <= lfsr_nxt;
      dused_r <= dused_nxt;
      fused_r <= fused_nxt;
      dcnt_r  <= dcnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r      <= w_nxt;
    scan_r   <= scan_nxt;
    dst_r    <= dst_nxt;
    t_r      <= t_nxt;
    base_r   <= base_nxt;
    len_r    <= len_nxt;
    f_r      <= f_nxt;
    div_r    <= div_nxt;
    idx_r    <= idx_nxt;
    wptr_r   <= wptr_nxt;
    rem_r    <= rem_nxt;
    status_r <= status_nxt;
    path_r   <= path_nxt;
    os_r     <= os_nxt;
    op_r     <= op_nxt;
  end

  assign out_valid         = ov_r;
  assign out_status        = os_r;
  assign out_assigned_path = op_r;

  psp_ram #(.W(32), .D(PATH_SLOTS)) u_def_paths (
    .clk(clk), .we(def_we), .waddr(def_wa), .wdata(w_r.path_id),
    .raddr(def_ra), .rdata(def_rd)
  );

  psp_ram #(.W(32), .D(DD)) u_dest_paths (
    .clk(clk), .we(dp_we), .waddr(dp_wa), .wdata(dp_wd),
    .raddr(dp_ra), .rdata(dp_rd)
  );

  psp_ram #(.W(32), .D(DEST_TABLES)) u_dest_keys (
    .clk(clk), .we(dk_we), .waddr(t_nxt), .wdata(w_r.dest_addr),
    .raddr(scan_r[TW-1:0]), .rdata(dk_rd)
  );

  psp_ram #(.W(CW), .D(DEST_TABLES)) u_dest_counts (
    .clk(clk), .we(dc_we), .waddr(t_nxt), .wdata(dc_wd),
    .raddr(scan_r[TW-1:0]), .rdata(dc_rd)
  );

  psp_ram #(.W(32), .D(FLOW_SLOTS)) u_flow_keys (
    .clk(clk), .we(fk_we), .waddr(f_nxt), .wdata(w_r.key),
    .raddr(scan_r[FW-1:0]), .rdata(fk_rd)
  );

  psp_ram #(.W(PW), .D(FLOW_SLOTS)) u_flow_next (
    .clk(clk), .we(fn_we), .waddr(f_r), .wdata(fn_wd),
    .raddr(scan_r[FW-1:0]), .rdata(fn_rd)
  );

  psp_mod #(.VW(CW)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(div_r),
    .divisor(len_r), .done(mod_done), .result(mod_res)
  );

endmodule
